>>> sv/cbgi_pkg.sv
`default_nettype none
package cbgi_pkg;
    localparam int DATA_W           = 32;
    localparam int MAX_TIME_KNOTS   = 64;
    localparam int MAX_STRIKE_KNOTS = 64;
    localparam int CNT_W            = 7;
    localparam int IDX_W            = 12;
    localparam int T_AW             = $clog2(MAX_TIME_KNOTS);
    localparam int S_AW             = $clog2(MAX_STRIKE_KNOTS);
    localparam int SURF_DEPTH       = MAX_TIME_KNOTS * MAX_STRIKE_KNOTS;
    localparam int SURF_AW          = $clog2(SURF_DEPTH);
    localparam int FRAC_W           = 16;
    localparam int W_W              = FRAC_W + 1;
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIKE_COUNT = 1'd1;

    typedef enum logic [1:0] {
        MODE_LOAD_TIME   = 2'd0,
        MODE_LOAD_STRIKE = 2'd1,
        MODE_LOAD_SURF   = 2'd2,
        MODE_QUERY       = 2'd3
    } t_mode;
endpackage
`default_nettype wire

>>> sv/cbgi_ram.sv
`default_nettype none
module cbgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/clamped_bilinear_grid_interpolator_core.sv
// clamped bilinear interpolator on a non-uniform grid, signed q16.16
// input channel (i_in_valid / o_in_stall) carries load and query items.
// modes 0 and 1 write a time or strike knot, mode 2 a row-major surface
// entry; loads give no result. mode 3 is a query.
// a query scans both knot memories in parallel, picks the cell and fetches
// its knots, runs two restoring dividers side by side for the weights,
// reads the four corners from the surface memory and blends them on one
// shared 18x34 multiplier; the output register then takes the result.
// only one query is worked on at a time; the length of the knot scan
// follows the larger of the two counts.
// the result sits in an output register (o_out_valid / i_out_stall); while
// it waits, load items are still taken, a new query is worked on and holds
// in its last step until the register is free.
// count registers must be written via the config port while idle; not enforced.
// synchronous reset returns both counts to 2 and clears control state;
// the memories are not cleared and must be loaded before use.
`default_nettype none
module clamped_bilinear_grid_interpolator_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [cbgi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cbgi_pkg::CNT_W-1:0]       i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_mode,
    input  wire logic [cbgi_pkg::IDX_W-1:0]       i_entry_index,
    input  wire logic signed [cbgi_pkg::DATA_W-1:0] i_load_value,
    input  wire logic signed [cbgi_pkg::DATA_W-1:0] i_query_time,
    input  wire logic signed [cbgi_pkg::DATA_W-1:0] i_query_log_moneyness,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [cbgi_pkg::DATA_W-1:0]    o_interpolated_value
);
    import cbgi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_END, S_CELL, S_FETCH_LO, S_FETCH_HI,
        S_FETCH_END, S_DIV_INIT, S_DIV, S_SURF, S_MUL, S_OUT
    } t_state;

    localparam int DW1 = DATA_W + 1;
    localparam int DW2 = DATA_W + 2;
    localparam int LO_W = DATA_W + FRAC_W + 2;
    localparam int ACC_W = 2 * DATA_W + 2;
    localparam int PROD_W = W_W + 1 + DW2;
    localparam int SPLIT = 25;

    t_state r_state;
    logic [CNT_W-1:0] r_tcount, r_scount;
    logic [CNT_W-1:0] tc, sc, nmax, r_cnt, r_rd_idx;
    logic             r_rd_vld;
    logic signed [DATA_W-1:0] r_qt, r_qs;
    logic signed [DATA_W-1:0] r_tk0, r_tkl, r_sk0, r_skl;
    logic [T_AW-1:0] r_tcand, r_ti;
    logic [S_AW-1:0] r_scand, r_si;
    logic signed [DATA_W-1:0] r_tlo, r_thi, r_slo, r_shi;
    logic signed [DATA_W-1:0] tq, sq;
    logic [T_AW-1:0] ti_c;
    logic [S_AW-1:0] si_c;

    // dividers
    logic [DW2-1:0] r_trem, r_srem, trem2, srem2;
    logic [DW1-1:0] r_tden, r_sden;
    logic [FRAC_W-1:0] r_tq16, r_sq16;
    logic r_tfix, r_sfix;
    logic [W_W-1:0] r_tfixv, r_sfixv, r_wt, r_ws;
    logic signed [DW1-1:0] tnum, tden, snum, sden;

    logic [SURF_AW-1:0] r_base;
    logic signed [DATA_W-1:0] r_v [4];
    logic signed [LO_W-1:0] r_lo, r_hi, r_d;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [W_W:0] ma;
    logic signed [DW2-1:0] mb;
    logic signed [PROD_W-1:0] prod;

    logic [T_AW-1:0] t_raddr;
    logic [S_AW-1:0] s_raddr;
    logic [SURF_AW-1:0] v_raddr;
    logic signed [DATA_W-1:0] t_rdata, s_rdata, v_rdata;
    logic in_xfer, t_we, s_we, v_we;
    logic [2*CNT_W-1:0] area;

    assign tc = (r_tcount < CNT_W'(2)) ? CNT_W'(2) :
                (r_tcount > CNT_W'(MAX_TIME_KNOTS)) ? CNT_W'(MAX_TIME_KNOTS) : r_tcount;
    assign sc = (r_scount < CNT_W'(2)) ? CNT_W'(2) :
                (r_scount > CNT_W'(MAX_STRIKE_KNOTS)) ? CNT_W'(MAX_STRIKE_KNOTS) : r_scount;
    assign nmax = (tc > sc) ? tc : sc;
    assign area = tc * sc;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer = i_in_valid && !o_in_stall;
    assign t_we = in_xfer && (i_mode == MODE_LOAD_TIME) && (i_entry_index < IDX_W'(tc));
    assign s_we = in_xfer && (i_mode == MODE_LOAD_STRIKE) && (i_entry_index < IDX_W'(sc));
    assign v_we = in_xfer && (i_mode == MODE_LOAD_SURF) &&
                  ({2'b0, i_entry_index} < area);

    always_comb begin
        t_raddr = '0;
        s_raddr = '0;
        case (r_state)
            S_SCAN: begin
                t_raddr = r_cnt[T_AW-1:0];
                s_raddr = r_cnt[S_AW-1:0];
            end
            S_FETCH_LO: begin
                t_raddr = r_ti;
                s_raddr = r_si;
            end
            S_FETCH_HI: begin
                t_raddr = r_ti + T_AW'(1);
                s_raddr = r_si + S_AW'(1);
            end
            default: ;
        endcase
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    v_raddr = r_base;
            2'd1:    v_raddr = r_base + SURF_AW'(1);
            2'd2:    v_raddr = r_base + SURF_AW'(sc);
            default: v_raddr = r_base + SURF_AW'(sc) + SURF_AW'(1);
        endcase
    end

    cbgi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TIME_KNOTS)) u_time_ram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(i_entry_index[T_AW-1:0]),
        .i_wdata(i_load_value), .i_raddr(t_raddr), .o_rdata(t_rdata)
    );
    cbgi_ram #(.WIDTH(DATA_W), .DEPTH(MAX_STRIKE_KNOTS)) u_strike_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(i_entry_index[S_AW-1:0]),
        .i_wdata(i_load_value), .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    cbgi_ram #(.WIDTH(DATA_W), .DEPTH(SURF_DEPTH)) u_surf_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(i_entry_index[SURF_AW-1:0]),
        .i_wdata(i_load_value), .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    // clamp and lower cell from the scan results
    always_comb begin
        tq = (r_qt < r_tk0) ? r_tk0 : ((r_qt > r_tkl) ? r_tkl : r_qt);
        sq = (r_qs < r_sk0) ? r_sk0 : ((r_qs > r_skl) ? r_skl : r_qs);
        ti_c = (tq <= r_tk0) ? '0 : ((tq >= r_tkl) ? T_AW'(tc - CNT_W'(2)) : r_tcand);
        si_c = (sq <= r_sk0) ? '0 : ((sq >= r_skl) ? S_AW'(sc - CNT_W'(2)) : r_scand);
    end

    assign tnum = DW1'(r_qt) - DW1'(r_tlo);
    assign tden = DW1'(r_thi) - DW1'(r_tlo);
    assign snum = DW1'(r_qs) - DW1'(r_slo);
    assign sden = DW1'(r_shi) - DW1'(r_slo);
    assign trem2 = {r_trem[DW2-2:0], 1'b0};
    assign srem2 = {r_srem[DW2-2:0], 1'b0};

    // shared multiplier
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_cnt)
            CNT_W'(0): begin
                ma = signed'({1'b0, r_ws});
                mb = DW2'(r_v[1]) - DW2'(r_v[0]);
            end
            CNT_W'(1): begin
                ma = signed'({1'b0, r_ws});
                mb = DW2'(r_v[3]) - DW2'(r_v[2]);
            end
            CNT_W'(3): begin
                ma = signed'({1'b0, r_wt});
                mb = signed'({{(DW2-SPLIT){1'b0}}, r_d[SPLIT-1:0]});
            end
            CNT_W'(4): begin
                ma = signed'({1'b0, r_wt});
                mb = DW2'(signed'(r_d[2*SPLIT-1:SPLIT]));
            end
            default: ;
        endcase
        prod = PROD_W'(ma) * PROD_W'(mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tcount    <= CNT_W'(2);
            r_scount    <= CNT_W'(2);
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TIME_COUNT) begin
                    r_tcount <= i_cfg_data;
                end else if (i_cfg_index == REG_STRIKE_COUNT) begin
                    r_scount <= i_cfg_data;
                end
            end
            if (r_state == S_OUT && (!o_out_valid || !i_out_stall)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            // scan data arrives in the cycle after its address
            if (r_rd_vld) begin
                if (r_rd_idx == '0) r_tk0 <= t_rdata;
                if (r_rd_idx == tc - CNT_W'(1)) r_tkl <= t_rdata;
                if (r_rd_idx != '0 && r_rd_idx + CNT_W'(1) < tc && t_rdata <= r_qt) begin
                    r_tcand <= r_rd_idx[T_AW-1:0];
                end
                if (r_rd_idx == '0) r_sk0 <= s_rdata;
                if (r_rd_idx == sc - CNT_W'(1)) r_skl <= s_rdata;
                if (r_rd_idx != '0 && r_rd_idx + CNT_W'(1) < sc && s_rdata <= r_qs) begin
                    r_scand <= r_rd_idx[S_AW-1:0];
                end
            end

            case (r_state)
                S_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (in_xfer && i_mode == MODE_QUERY) begin
                        r_qt    <= i_query_time;
                        r_qs    <= i_query_log_moneyness;
                        r_tcand <= '0;
                        r_scand <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_idx <= r_cnt;
                    r_rd_vld <= 1'b1;
                    r_cnt    <= r_cnt + CNT_W'(1);
                    if (r_cnt == nmax - CNT_W'(1)) begin
                        r_state <= S_SCAN_END;
                    end
                end
                S_SCAN_END: begin
                    r_rd_vld <= 1'b0;
                    r_state  <= S_CELL;
                end
                S_CELL: begin
                    r_qt    <= tq;
                    r_qs    <= sq;
                    r_ti    <= ti_c;
                    r_si    <= si_c;
                    r_state <= S_FETCH_LO;
                end
                S_FETCH_LO: r_state <= S_FETCH_HI;
                S_FETCH_HI: begin
                    r_tlo   <= t_rdata;
                    r_slo   <= s_rdata;
                    r_state <= S_FETCH_END;
                end
                S_FETCH_END: begin
                    r_thi   <= t_rdata;
                    r_shi   <= s_rdata;
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_base <= SURF_AW'(r_ti) * SURF_AW'(sc) + SURF_AW'(r_si);
                    r_tfix <= (tden <= 0) || (tnum <= 0) || (tnum >= tden);
                    r_tfixv <= ((tden > 0) && (tnum > 0)) ? W_W'(1) << FRAC_W : '0;
                    r_trem <= DW2'(unsigned'(tnum));
                    r_tden <= unsigned'(tden);
                    r_sfix <= (sden <= 0) || (snum <= 0) || (snum >= sden);
                    r_sfixv <= ((sden > 0) && (snum > 0)) ? W_W'(1) << FRAC_W : '0;
                    r_srem <= DW2'(unsigned'(snum));
                    r_sden <= unsigned'(sden);
                    r_cnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle, remainder < divisor unless fixed
                    if (trem2 >= DW2'(r_tden)) begin
                        r_trem <= trem2 - DW2'(r_tden);
                        r_tq16 <= {r_tq16[FRAC_W-2:0], 1'b1};
                    end else begin
                        r_trem <= trem2;
                        r_tq16 <= {r_tq16[FRAC_W-2:0], 1'b0};
                    end
                    if (srem2 >= DW2'(r_sden)) begin
                        r_srem <= srem2 - DW2'(r_sden);
                        r_sq16 <= {r_sq16[FRAC_W-2:0], 1'b1};
                    end else begin
                        r_srem <= srem2;
                        r_sq16 <= {r_sq16[FRAC_W-2:0], 1'b0};
                    end
                    if (r_cnt == CNT_W'(FRAC_W)) begin
                        r_wt    <= r_tfix ? r_tfixv : {1'b0, r_tq16};
                        r_ws    <= r_sfix ? r_sfixv : {1'b0, r_sq16};
                        r_cnt   <= '0;
                        r_state <= S_SURF;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_SURF: begin
                    if (r_cnt != '0) begin
                        r_v[r_cnt[1:0] - 2'd1] <= v_rdata;
                    end
                    if (r_cnt == CNT_W'(4)) begin
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    case (r_cnt)
                        CNT_W'(0): r_lo <= (LO_W'(r_v[0]) <<< FRAC_W) + LO_W'(prod);
                        CNT_W'(1): r_hi <= (LO_W'(r_v[2]) <<< FRAC_W) + LO_W'(prod);
                        CNT_W'(2): r_d  <= r_hi - r_lo;
                        CNT_W'(3): r_acc <= (ACC_W'(r_lo) <<< FRAC_W) + ACC_W'(prod);
                        default: begin
                            r_acc   <= r_acc + (ACC_W'(prod) <<< SPLIT);
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_interpolated_value <= r_acc[2*DATA_W-1:DATA_W];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT)) else $error("result without blend");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= CNT_W'(FRAC_W)) else $error("divider overran");
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_in_stall && !t_we && !v_we) else $error("load while busy");
`endif
endmodule
`default_nettype wire

>>> dv/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbgi_pkg::*;

    localparam int QUIET_CYCLES = 120;

    typedef enum logic [1:0] {K_ITEM, K_CFG, K_HOLD} t_kind;
    typedef struct {
        t_kind                  kind;
        t_mode                  mode;
        logic [IDX_W-1:0]       idx;
        logic [DATA_W-1:0]      lv;
        logic [DATA_W-1:0]      qt;
        logic [DATA_W-1:0]      qm;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CNT_W-1:0]       reg_val;
    } t_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [CNT_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             mode_r = 2'd0;
    logic [IDX_W-1:0]       idx_r = '0;
    logic signed [DATA_W-1:0] lv_r = '0, qt_r = '0, qm_r = '0;
    logic                   o_out_valid;
    logic                   out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_interpolated_value;

    clamped_bilinear_grid_interpolator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_mode(mode_r), .i_entry_index(idx_r), .i_load_value(lv_r),
        .i_query_time(qt_r), .i_query_log_moneyness(qm_r),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_interpolated_value(o_interpolated_value)
    );

    // predictor copy of the block state
    logic [CNT_W-1:0] m_tc = 7'd2, m_sc = 7'd2;
    int m_tk [MAX_TIME_KNOTS];
    int m_sk [MAX_STRIKE_KNOTS];
    int m_sv [SURF_DEPTH];

    t_item pending [$];
    logic [DATA_W-1:0] expected_vals [$];
    int errors = 0;
    int n_queries = 0, n_loads = 0, n_results = 0, n_cfg = 0;
    int quiet = 0, in_gap = 0, out_wait = 0, calm_cnt = 0;
    bit calm = 1'b0;

    initial forever #5 i_clk = ~i_clk;

    function automatic int eff_count(logic [CNT_W-1:0] r, int maxv);
        if (r < 2) return 2;
        if (r > maxv) return maxv;
        return int'(r);
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic longint frac_weight(int lo, int hi, int p);
        longint num, den;
        num = longint'(p) - longint'(lo);
        den = longint'(hi) - longint'(lo);
        if (den <= 0 || num <= 0) return 0;
        if (num >= den) return 65536;
        return (num * 65536) / den;
    endfunction

    function automatic logic [DATA_W-1:0] bilinear(int qt, int qm);
        int tc, sc, t, s, ti, si;
        longint wt, ws, v00, v01, v10, v11, lo_b, hi_b;
        logic [63:0] sum;
        tc = eff_count(m_tc, MAX_TIME_KNOTS);
        sc = eff_count(m_sc, MAX_STRIKE_KNOTS);
        t = (qt < m_tk[0]) ? m_tk[0] : ((qt > m_tk[tc-1]) ? m_tk[tc-1] : qt);
        s = (qm < m_sk[0]) ? m_sk[0] : ((qm > m_sk[sc-1]) ? m_sk[sc-1] : qm);
        ti = 0;
        if (t > m_tk[0]) begin
            if (t >= m_tk[tc-1]) ti = tc - 2;
            else
                for (int i = 1; i + 1 < tc; i++) if (m_tk[i] <= t) ti = i;
        end
        si = 0;
        if (s > m_sk[0]) begin
            if (s >= m_sk[sc-1]) si = sc - 2;
            else
                for (int i = 1; i + 1 < sc; i++) if (m_sk[i] <= s) si = i;
        end
        wt = frac_weight(m_tk[ti], m_tk[ti+1], t);
        ws = frac_weight(m_sk[si], m_sk[si+1], s);
        v00 = m_sv[ti*sc + si];
        v01 = m_sv[ti*sc + si + 1];
        v10 = m_sv[(ti+1)*sc + si];
        v11 = m_sv[(ti+1)*sc + si + 1];
        lo_b = (65536 - ws) * v00 + ws * v01;
        hi_b = (65536 - ws) * v10 + ws * v11;
        sum = (65536 - wt) * lo_b + wt * hi_b;
        return sum[63:32];
    endfunction

    function automatic void apply_item(t_item it);
        int tc, sc;
        tc = eff_count(m_tc, MAX_TIME_KNOTS);
        sc = eff_count(m_sc, MAX_STRIKE_KNOTS);
        case (it.mode)
            MODE_LOAD_TIME:   if (it.idx < tc) m_tk[it.idx] = it.lv;
            MODE_LOAD_STRIKE: if (it.idx < sc) m_sk[it.idx] = it.lv;
            MODE_LOAD_SURF:   if (it.idx < tc * sc) m_sv[it.idx] = it.lv;
            default: begin
                expected_vals.push_back(bilinear(it.qt, it.qm));
                n_queries++;
            end
        endcase
        if (it.mode != MODE_QUERY) n_loads++;
    endfunction

    task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // input side: one transfer per accepted item, config writes only when quiet
    always @(posedge i_clk) begin
        bit fire, nv, nwe;
        t_item it;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            cfg_we <= 1'b0;
        end else begin
            calm_cnt++;
            if (calm_cnt >= 300) begin
                calm_cnt = 0;
                calm = ($urandom_range(0, 2) == 0);
            end
            fire = in_valid && !o_in_stall;
            if (fire) begin
                it.kind = K_ITEM;
                it.mode = t_mode'(mode_r);
                it.idx = idx_r; it.lv = lv_r; it.qt = qt_r; it.qm = qm_r;
                apply_item(it);
            end
            if (in_valid || expected_vals.size() != 0) quiet = 0;
            else quiet++;
            nv = in_valid && !fire;
            nwe = 1'b0;
            if (!nv && pending.size() != 0) begin
                if (pending[0].kind == K_ITEM) begin
                    if (in_gap > 0) in_gap--;
                    else begin
                        it = pending.pop_front();
                        mode_r <= it.mode; idx_r <= it.idx; lv_r <= it.lv;
                        qt_r <= it.qt; qm_r <= it.qm;
                        nv = 1'b1;
                        in_gap = draw_wait();
                    end
                end else if (quiet >= QUIET_CYCLES && !fire) begin
                    it = pending.pop_front();
                    quiet = 0;
                    if (it.kind == K_CFG) begin
                        nwe = 1'b1;
                        cfg_idx <= it.reg_idx;
                        cfg_data <= it.reg_val;
                        if (it.reg_idx == REG_TIME_COUNT) m_tc = it.reg_val;
                        else m_sc = it.reg_val;
                        n_cfg++;
                    end
                end
            end
            in_valid <= nv;
            cfg_we <= nwe;
        end
    end

    // result side
    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                n_results++;
                if (expected_vals.size() == 0)
                    report("unexpected result", o_interpolated_value, '0);
                else begin
                    want = expected_vals.pop_front();
                    if (o_interpolated_value !== want)
                        report("interpolated_value", o_interpolated_value, want);
                end
                out_wait = draw_wait();
            end else if (o_out_valid && out_stall && out_wait > 0) begin
                out_wait--;
            end
            out_stall <= (out_wait != 0);
        end
    end

    function automatic void push_load(t_mode m, int idx, logic [DATA_W-1:0] v);
        t_item it;
        it.kind = K_ITEM; it.mode = m; it.idx = IDX_W'(idx); it.lv = v;
        it.qt = $urandom; it.qm = $urandom;
        it.reg_idx = '0; it.reg_val = '0;
        pending.push_back(it);
    endfunction

    function automatic void push_query(logic [DATA_W-1:0] t, logic [DATA_W-1:0] s);
        t_item it;
        it.kind = K_ITEM; it.mode = MODE_QUERY; it.idx = IDX_W'($urandom); it.lv = $urandom;
        it.qt = t; it.qm = s; it.reg_idx = '0; it.reg_val = '0;
        pending.push_back(it);
    endfunction

    function automatic void push_ctl(t_kind k, logic [CFG_IDX_W-1:0] r, logic [CNT_W-1:0] v);
        t_item it;
        it.kind = k; it.mode = MODE_QUERY; it.idx = '0; it.lv = '0;
        it.qt = '0; it.qm = '0; it.reg_idx = r; it.reg_val = v;
        pending.push_back(it);
    endfunction

    // grid style: 0 sorted full range, 1 narrow non-decreasing, 2 flat
    function automatic void make_grid(int n, int style, ref int g[$]);
        int base;
        g.delete();
        base = $urandom_range(0, 2097152) - 1048576;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: g.push_back($urandom);
                1: begin
                    g.push_back(base);
                    base += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 262144);
                end
                default: g.push_back(base);
            endcase
        end
        if (style == 0) g.sort();
    endfunction

    function automatic logic [DATA_W-1:0] pick_point(int g[$]);
        int k;
        k = $urandom_range(0, g.size() - 1);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return g[k];
            2: return g[0] - $urandom_range(0, 70000);
            3: return g[g.size()-1] + $urandom_range(0, 70000);
            default: return g[k] + $urandom_range(0, 131072) - 65536;
        endcase
    endfunction

    function automatic void add_phase(bit do_cfg, int rtc, int rsc, int style, int nrand);
        int tc, sc, tg[$], sg[$], r;
        if (do_cfg) begin
            push_ctl(K_CFG, REG_TIME_COUNT, rtc[CNT_W-1:0]);
            push_ctl(K_CFG, REG_STRIKE_COUNT, rsc[CNT_W-1:0]);
        end
        tc = eff_count(rtc[CNT_W-1:0], MAX_TIME_KNOTS);
        sc = eff_count(rsc[CNT_W-1:0], MAX_STRIKE_KNOTS);
        make_grid(tc, style, tg);
        make_grid(sc, (style == 2) ? 1 : style, sg);
        for (int i = 0; i < tc; i++) push_load(MODE_LOAD_TIME, i, tg[i]);
        for (int i = 0; i < sc; i++) push_load(MODE_LOAD_STRIKE, i, sg[i]);
        for (int i = 0; i < tc * sc; i++) push_load(MODE_LOAD_SURF, i, $urandom);
        for (int n = 0; n < nrand; n++) begin
            if (n == nrand / 2) push_ctl(K_HOLD, '0, '0);
            r = $urandom_range(0, 99);
            if (r < 72) push_query(pick_point(tg), pick_point(sg));
            else if (r < 84) push_load(MODE_LOAD_SURF, $urandom_range(0, tc*sc-1), $urandom);
            else if (r < 87) push_load(MODE_LOAD_TIME, $urandom_range(0, tc-1), $urandom);
            else if (r < 90) push_load(MODE_LOAD_STRIKE, $urandom_range(0, sc-1), $urandom);
            else if (r < 94) push_load(MODE_LOAD_SURF, $urandom_range(tc*sc, 4095), $urandom);
            else if (r < 97) push_load(MODE_LOAD_TIME, $urandom_range(tc, 4095), $urandom);
            else push_load(MODE_LOAD_STRIKE, $urandom_range(sc, 4095), $urandom);
        end
    endfunction

    initial begin
        int cnt_pairs [4][2] = '{'{0, 1}, '{127, 0}, '{5, 7}, '{3, 3}};
        // directed: reset counts, time grid ends at the number range extremes
        push_load(MODE_LOAD_TIME, 0, 32'h8000_0000);
        push_load(MODE_LOAD_TIME, 1, 32'h7fff_ffff);
        push_load(MODE_LOAD_STRIKE, 0, 32'h0000_0000);
        push_load(MODE_LOAD_STRIKE, 1, 32'h0001_0000);
        push_load(MODE_LOAD_SURF, 0, 32'h8000_0000);
        push_load(MODE_LOAD_SURF, 1, 32'h7fff_ffff);
        push_load(MODE_LOAD_SURF, 2, 32'h7fff_ffff);
        push_load(MODE_LOAD_SURF, 3, 32'h8000_0000);
        push_load(MODE_LOAD_SURF, 4, 32'h1234_5678);
        push_load(MODE_LOAD_TIME, 2, 32'h0);
        push_load(MODE_LOAD_STRIKE, 4095, 32'hffff_ffff);
        push_query(32'h8000_0000, 32'h8000_0000);
        push_query(32'h7fff_ffff, 32'h7fff_ffff);
        push_query(32'h0, 32'h0000_8000);
        push_query(32'hffff_ffff, 32'h0001_0000);
        push_query(32'h8000_0000, 32'h7fff_ffff);
        push_query(32'h7fff_ffff, 32'hffff_ffff);
        push_query(32'h4000_0000, 32'h0000_0001);
        push_ctl(K_HOLD, '0, '0);
        // flat time grid: every cell is degenerate
        push_load(MODE_LOAD_TIME, 0, 32'h0000_0005);
        push_load(MODE_LOAD_TIME, 1, 32'h0000_0005);
        push_query(32'h0000_0005, 32'h0000_c000);
        push_query(32'h0000_0004, 32'h0001_0001);
        for (int p = 0; p < 4; p++)
            add_phase(1'b1, cnt_pairs[p][0], cnt_pairs[p][1], (p == 3) ? 2 : p % 2, 40);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending.size() == 0 && !in_valid);
        wait (expected_vals.size() == 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        $display("tb: %0d queries and %0d loads over %0d count writes, %0d results checked",
                 n_queries, n_loads, n_cfg, n_results);
        $display("tb: grids full range, narrow and flat, counts from below 2 to above 64");
        if (errors == 0 && expected_vals.size() == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: timeout");
        $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

>>> clamped_bilinear_grid_interpolator_core.f
sv/cbgi_pkg.sv
sv/cbgi_ram.sv
sv/clamped_bilinear_grid_interpolator_core.sv
dv/tb.sv
